// ===== rtl/process_id_slot_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Process id slot allocator assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PROCESS_ID_SLOT_ALLOCATOR_DEFINES_SVH
`define PROCESS_ID_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define PIDSA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pidsa: same-cycle check failed");

`define PIDSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pidsa: next-cycle check failed");

`else

`define PIDSA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define PIDSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/pidsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Process id slot allocator package
// Field widths, request and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package pidsa_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned PID_W    = 7;
  localparam int unsigned OWNER_W  = 16;
  localparam int unsigned START_W  = 6;
  localparam int unsigned EXIT_W   = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MODE_W-1:0] MODE_ALLOC    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET_EXIT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SET_EXIT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  localparam logic [EXIT_W-1:0] EXIT_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic clr_pass;
    logic capture;
    logic reduce;
    logic probe;
    logic access;
    logic finish;
    logic emit;
  } pidsa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic req_alloc;
    logic slot_in_range;
    logic probe_done;
    logic out_free;
  } pidsa_sts_t;

endpackage

// ===== rtl/pidsa_if.sv =====
// ----------------------------------------------------------------------------
// Process id slot allocator channels
// Request and result channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface pidsa_in_if import pidsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [PID_W-1:0]          pid;
  logic [OWNER_W-1:0]        owner_handle;
  logic [START_W-1:0]        start_slot;
  logic signed [EXIT_W-1:0]  exit_code;

  modport source (output valid, mode, pid, owner_handle, start_slot, exit_code,
                  input ready);
  modport sink (input valid, mode, pid, owner_handle, start_slot, exit_code,
                output ready);
endinterface

interface pidsa_out_if import pidsa_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PID_W-1:0]          new_pid;
  logic [OWNER_W-1:0]        owner_out;
  logic                      owner_valid;
  logic signed [EXIT_W-1:0]  exit_out;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, new_pid, owner_out, owner_valid, exit_out, status,
                  input ready);
  modport sink (input valid, new_pid, owner_out, owner_valid, exit_out, status,
                output ready);
endinterface

// ===== rtl/pidsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// Process id slot allocator controller
// Sequences the clearing pass, the allocation probe and table accesses.
// ----------------------------------------------------------------------------
module pidsa_ctrl import pidsa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pidsa_sts_t sts,
  output pidsa_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_REDUCE = 7'b0000100,
    S_PROBE  = 7'b0001000,
    S_ACCESS = 7'b0010000,
    S_FINISH = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_pass = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.req_alloc ? S_REDUCE : S_ACCESS;
        end
      end
      S_REDUCE: begin
        cmd.reduce = 1'b1;
        if (sts.slot_in_range) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/pidsa_dp.sv =====
// ----------------------------------------------------------------------------
// Process id slot allocator datapath
// Slot tables, probe pointer, request registers and the result register.
// ----------------------------------------------------------------------------
module pidsa_dp import pidsa_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pidsa_cmd_t               cmd,
  output pidsa_sts_t               sts,
  input  logic [MODE_W-1:0]        in_mode,
  input  logic [PID_W-1:0]         in_pid,
  input  logic [OWNER_W-1:0]       in_owner_handle,
  input  logic [START_W-1:0]       in_start_slot,
  input  logic signed [EXIT_W-1:0] in_exit_code,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PID_W-1:0]         out_new_pid,
  output logic [OWNER_W-1:0]       out_owner_out,
  output logic                     out_owner_valid,
  output logic signed [EXIT_W-1:0] out_exit_out,
  output logic [STATUS_W-1:0]      out_status
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned SW    = (IDX_W > START_W) ? IDX_W : START_W;
  localparam int unsigned CW0   = $clog2(SLOTS + 1);
  localparam int unsigned CW    = (CW0 > PID_W) ? CW0 : PID_W;

  logic                used_mem  [SLOTS];
  logic [OWNER_W-1:0]  owner_mem [SLOTS];
  logic [EXIT_W-1:0]   exit_mem  [SLOTS];

  logic                used_q;
  logic [OWNER_W-1:0]  owner_q;
  logic [EXIT_W-1:0]   exit_q;

  logic [IDX_W-1:0]    clr_r;
  logic [SW-1:0]       slot_r;
  logic [IDX_W-1:0]    probes_r;
  logic [MODE_W-1:0]   mode_r;
  logic [IDX_W-1:0]    pid_idx_r;
  logic                pid_ok_r;
  logic [OWNER_W-1:0]  owner_r;
  logic [EXIT_W-1:0]   code_r;

  logic [PID_W-1:0]    res_new_pid_r, res_new_pid_nxt;
  logic [OWNER_W-1:0]  res_owner_r, res_owner_nxt;
  logic                res_owner_valid_r, res_owner_valid_nxt;
  logic [EXIT_W-1:0]   res_exit_r, res_exit_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                out_valid_r;
  logic [PID_W-1:0]    out_new_pid_r;
  logic [OWNER_W-1:0]  out_owner_r;
  logic                out_owner_valid_r;
  logic [EXIT_W-1:0]   out_exit_r;
  logic [STATUS_W-1:0] out_status_r;

  logic [IDX_W-1:0]    slot_idx;
  logic [IDX_W-1:0]    next_idx;
  logic                slot_ge;
  logic [SW-1:0]       slot_sub;
  logic                probe_last;
  logic                take;
  logic [CW-1:0]       pid_m1;
  logic                in_pid_ok;

  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                used_we, used_wd;
  logic                owner_we;
  logic                exit_we;
  logic [EXIT_W-1:0]   exit_wd;

  assign slot_idx   = slot_r[IDX_W-1:0];
  assign next_idx   = (slot_idx == IDX_W'(SLOTS - 1)) ? IDX_W'(1) : slot_idx + 1'b1;
  assign slot_ge    = {1'b0, slot_r} >= (SW + 1)'(SLOTS);
  assign slot_sub   = SW'({1'b0, slot_r} - (SW + 1)'(SLOTS));
  assign probe_last = probes_r == IDX_W'(SLOTS - 1);
  assign take       = cmd.probe && !used_q;
  assign pid_m1     = CW'(in_pid) - CW'(1);
  assign in_pid_ok  = (in_pid != '0) && (CW'(in_pid) <= CW'(SLOTS));

  assign sts.clr_last      = clr_r == IDX_W'(SLOTS - 1);
  assign sts.req_alloc     = in_mode == MODE_ALLOC;
  assign sts.slot_in_range = !slot_ge;
  assign sts.probe_done    = !used_q || probe_last;
  assign sts.out_free      = !out_valid_r || out_ready;

  always_comb begin
    if (cmd.reduce) begin
      rd_addr = slot_idx;
    end else if (cmd.probe) begin
      rd_addr = next_idx;
    end else begin
      rd_addr = pid_idx_r;
    end
  end

  always_comb begin
    wr_addr  = pid_idx_r;
    used_we  = 1'b0;
    used_wd  = 1'b0;
    owner_we = 1'b0;
    exit_we  = 1'b0;
    exit_wd  = EXIT_RESET;
    if (cmd.clr_pass) begin
      wr_addr = clr_r;
      used_we = 1'b1;
      exit_we = 1'b1;
    end else if (take) begin
      wr_addr  = slot_idx;
      used_we  = 1'b1;
      used_wd  = 1'b1;
      owner_we = 1'b1;
      exit_we  = 1'b1;
    end else if (cmd.access && pid_ok_r) begin
      used_we = mode_r == MODE_CLEAR;
      exit_we = mode_r == MODE_SET_EXIT;
      exit_wd = code_r;
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      used_mem[wr_addr] <= used_wd;
    end
    used_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (owner_we) begin
      owner_mem[wr_addr] <= owner_r;
    end
    owner_q <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (exit_we) begin
      exit_mem[wr_addr] <= exit_wd;
    end
    exit_q <= exit_mem[rd_addr];
  end

  always_comb begin
    res_new_pid_nxt     = res_new_pid_r;
    res_owner_nxt       = res_owner_r;
    res_owner_valid_nxt = res_owner_valid_r;
    res_exit_nxt        = res_exit_r;
    res_status_nxt      = res_status_r;
    if (cmd.probe && sts.probe_done) begin
      res_owner_nxt       = '0;
      res_owner_valid_nxt = 1'b0;
      res_exit_nxt        = '0;
      if (!used_q) begin
        res_new_pid_nxt = PID_W'(CW'(slot_idx) + CW'(1));
        res_status_nxt  = ST_OK;
      end else begin
        res_new_pid_nxt = '0;
        res_status_nxt  = ST_FULL;
      end
    end else if (cmd.finish) begin
      res_new_pid_nxt     = '0;
      res_owner_nxt       = '0;
      res_owner_valid_nxt = 1'b0;
      res_exit_nxt        = '0;
      res_status_nxt      = ST_OK;
      unique case (mode_r)
        MODE_LOOKUP: begin
          if (!pid_ok_r) begin
            res_status_nxt = ST_RANGE;
          end else if (used_q) begin
            res_owner_nxt       = owner_q;
            res_owner_valid_nxt = 1'b1;
          end
        end
        MODE_GET_EXIT: begin
          if (!pid_ok_r) begin
            res_status_nxt = ST_RANGE;
          end else begin
            res_exit_nxt = exit_q;
          end
        end
        MODE_SET_EXIT: begin
          if (!pid_ok_r) begin
            res_status_nxt = ST_RANGE;
          end
        end
        default: begin
          res_status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res_new_pid_r     <= res_new_pid_nxt;
    res_owner_r       <= res_owner_nxt;
    res_owner_valid_r <= res_owner_valid_nxt;
    res_exit_r        <= res_exit_nxt;
    res_status_r      <= res_status_nxt;
    if (cmd.capture) begin
      mode_r    <= in_mode;
      pid_idx_r <= pid_m1[IDX_W-1:0];
      pid_ok_r  <= in_pid_ok;
      owner_r   <= in_owner_handle;
      code_r    <= in_exit_code;
      slot_r    <= SW'(in_start_slot);
      probes_r  <= IDX_W'(1);
    end else if (cmd.reduce && slot_ge) begin
      slot_r <= slot_sub;
    end else if (cmd.probe && !sts.probe_done) begin
      slot_r   <= SW'(next_idx);
      probes_r <= probes_r + 1'b1;
    end
    if (cmd.emit) begin
      out_new_pid_r     <= res_new_pid_r;
      out_owner_r       <= res_owner_r;
      out_owner_valid_r <= res_owner_valid_r;
      out_exit_r        <= res_exit_r;
      out_status_r      <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_pass) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_pid     = out_new_pid_r;
  assign out_owner_out   = out_owner_r;
  assign out_owner_valid = out_owner_valid_r;
  assign out_exit_out    = out_exit_r;
  assign out_status      = out_status_r;

endmodule

// ===== rtl/process_id_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// Process id slot allocator
// Requests arrive on in_ch (valid/ready) with a mode, an id, an owner handle,
// a probe start slot and an exit code. Each accepted beat yields exactly one
// result beat on out_ch carrying the new id, owner, exit code and a status.
// Lookup, exit-code and clear requests pass through the capture, access and
// finish steps into the result register. An allocation is captured, then
// SLOTS is subtracted from the start slot until it is in range, and then a
// linear probe examines one slot per cycle through the used-mark memory read
// port, passing over occupied slots until it finds a free one or gives up.
// One request is in flight at a time. After reset the block clears the used
// marks and presets the exit codes of every slot, with in_ch.ready low. A
// stalled result beat stays in the output register; the next request may be
// accepted meanwhile and its result waits until the output register is free.
// ----------------------------------------------------------------------------
`include "process_id_slot_allocator_defines.svh"

module process_id_slot_allocator import pidsa_pkg::*; #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pidsa_in_if.sink    in_ch,
  pidsa_out_if.source out_ch
);

  pidsa_cmd_t cmd;
  pidsa_sts_t sts;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  pidsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pidsa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_ch.mode),
    .in_pid          (in_ch.pid),
    .in_owner_handle (in_ch.owner_handle),
    .in_start_slot   (in_ch.start_slot),
    .in_exit_code    (in_ch.exit_code),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_new_pid     (out_ch.new_pid),
    .out_owner_out   (out_ch.owner_out),
    .out_owner_valid (out_ch.owner_valid),
    .out_exit_out    (out_ch.exit_out),
    .out_status      (out_ch.status)
  );

  `PIDSA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
  `PIDSA_ASSERT_IMP(a_full_no_pid, clk, rst_n, out_ch.valid && (out_ch.status != ST_OK), out_ch.new_pid == '0 && !out_ch.owner_valid)
  `PIDSA_ASSERT_IMP(a_pid_in_range, clk, rst_n, out_ch.valid && (out_ch.new_pid != '0), out_ch.status == ST_OK && !out_ch.owner_valid)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// Process id slot allocator testbench
// Drives allocate, lookup, exit-code and clear requests through the request
// channel under random bursts and result back-pressure. A scoreboard keeps
// its own slot table, predicts every result beat at acceptance, and compares
// each result beat field by field in order.
// ----------------------------------------------------------------------------
module tb import pidsa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOTS      = 64;
  localparam int unsigned PERIOD      = 10;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT  = 3000;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_ITEMS = 108;
  localparam logic [MODE_W-1:0] MODE_LAST = '1;
  localparam logic [PID_W-1:0]  PID_LAST  = '1;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [PID_W-1:0]         pid;
    logic [OWNER_W-1:0]       owner_handle;
    logic [START_W-1:0]       start_slot;
    logic signed [EXIT_W-1:0] exit_code;
  } pid_req_t;

  typedef struct {
    logic [PID_W-1:0]         new_pid;
    logic [OWNER_W-1:0]       owner_out;
    logic                     owner_valid;
    logic signed [EXIT_W-1:0] exit_out;
    logic [STATUS_W-1:0]      status;
  } pid_res_t;

  class slot_table_sb;
    bit                 used_mark[NSLOTS];
    logic [OWNER_W-1:0] owner_tab[NSLOTS];
    logic [EXIT_W-1:0]  exit_tab[NSLOTS];
    pid_res_t           expected_replies[$];
    int                 errors;

    function new();
      foreach (used_mark[k]) begin
        used_mark[k] = 1'b0;
        owner_tab[k] = '0;
        exit_tab[k]  = EXIT_RESET;
      end
      errors = 0;
    endfunction

    function pid_res_t apply_request(pid_req_t q);
      pid_res_t    o;
      int unsigned slot;
      int unsigned probes;
      bit          id_ok;
      o = '{default: '0};
      id_ok = (q.pid >= 1) && (q.pid <= NSLOTS);
      slot = q.pid - 1;
      case (q.mode)
        MODE_ALLOC: begin
          slot = q.start_slot % NSLOTS;
          probes = 1;
          while (used_mark[slot] && probes < NSLOTS) begin
            probes++;
            slot++;
            if (slot >= NSLOTS) begin
              slot = 1;
            end
          end
          if (probes < NSLOTS) begin
            used_mark[slot] = 1'b1;
            owner_tab[slot] = q.owner_handle;
            exit_tab[slot]  = EXIT_RESET;
            o.new_pid = PID_W'(slot + 1);
          end else begin
            o.status = ST_FULL;
          end
        end
        MODE_LOOKUP, MODE_GET_EXIT, MODE_SET_EXIT: begin
          if (!id_ok) begin
            o.status = ST_RANGE;
          end else if (q.mode == MODE_LOOKUP) begin
            if (used_mark[slot]) begin
              o.owner_out   = owner_tab[slot];
              o.owner_valid = 1'b1;
            end
          end else if (q.mode == MODE_GET_EXIT) begin
            o.exit_out = exit_tab[slot];
          end else begin
            exit_tab[slot] = q.exit_code;
          end
        end
        MODE_CLEAR: begin
          if (id_ok) begin
            used_mark[slot] = 1'b0;
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(pid_req_t q);
      expected_replies.push_back(apply_request(q));
    endfunction

    function void mismatch(string field, logic signed [63:0] e, logic signed [63:0] a);
      $error("%s: expected %0d, got %0d", field, e, a);
      errors++;
    endfunction

    function void check_result(pid_res_t a);
      pid_res_t e;
      if (expected_replies.size() == 0) begin
        $error("result beat with no request outstanding");
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      if (a.new_pid !== e.new_pid) mismatch("new_pid", e.new_pid, a.new_pid);
      if (a.owner_out !== e.owner_out) mismatch("owner_out", e.owner_out, a.owner_out);
      if (a.owner_valid !== e.owner_valid) begin
        mismatch("owner_valid", e.owner_valid, a.owner_valid);
      end
      if (a.exit_out !== e.exit_out) mismatch("exit_out", e.exit_out, a.exit_out);
      if (a.status !== e.status) mismatch("status", e.status, a.status);
    endfunction

    function int outstanding();
      return expected_replies.size();
    endfunction

    function int pick_used_id();
      int ids[$];
      foreach (used_mark[k]) begin
        if (used_mark[k]) ids.push_back(k + 1);
      end
      if (ids.size() == 0) return 0;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_req = 1'b0;
  int   idle_cycles = 0;
  slot_table_sb sb;

  pidsa_in_if  in_ch();
  pidsa_out_if out_ch();

  process_id_slot_allocator #(.SLOTS(NSLOTS)) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #(PERIOD / 2) clk = ~clk;

  task automatic send_request(pid_req_t q);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= q.mode;
    in_ch.pid          <= q.pid;
    in_ch.owner_handle <= q.owner_handle;
    in_ch.start_slot   <= q.start_slot;
    in_ch.exit_code    <= q.exit_code;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic issue(logic [MODE_W-1:0] m, logic [PID_W-1:0] p, logic [OWNER_W-1:0] o,
                       logic [START_W-1:0] s, logic [EXIT_W-1:0] c);
    pid_req_t q;
    q.mode = m;
    q.pid = p;
    q.owner_handle = o;
    q.start_slot = s;
    q.exit_code = c;
    send_request(q);
  endtask

  task automatic idle_sender(int n);
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic pid_req_t random_request(int alloc_pct, int clear_pct);
    pid_req_t q;
    int       r;
    int       u;
    int       used_id;
    r = $urandom_range(0, 99);
    u = $urandom_range(0, 99);
    used_id = sb.pick_used_id();
    q.owner_handle = OWNER_W'($urandom);
    q.start_slot = ($urandom_range(0, 9) == 0) ? '0 : START_W'($urandom);
    q.exit_code = $urandom;
    if (r < alloc_pct) begin
      q.mode = MODE_ALLOC;
    end else if (r < alloc_pct + clear_pct) begin
      q.mode = MODE_CLEAR;
    end else if (r >= 97) begin
      q.mode = MODE_W'($urandom_range(MODE_CLEAR + 1, MODE_LAST));
    end else begin
      q.mode = MODE_W'($urandom_range(MODE_LOOKUP, MODE_SET_EXIT));
    end
    if (u < 6) begin
      q.pid = '0;
    end else if (u < 12) begin
      q.pid = PID_W'($urandom_range(NSLOTS + 1, PID_LAST));
    end else if (u < 70 && used_id != 0) begin
      q.pid = PID_W'(used_id);
    end else begin
      q.pid = PID_W'($urandom_range(1, NSLOTS));
    end
    return q;
  endfunction

  initial begin : result_sink
    int style;
    int left;
    style = 0;
    left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left = $urandom_range(10, 150);
      end
      left--;
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= ($urandom_range(0, 99) < 85);
      endcase
    end
  end

  always @(posedge clk) begin
    pid_res_t a;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a.new_pid = out_ch.new_pid;
      a.owner_out = out_ch.owner_out;
      a.owner_valid = out_ch.owner_valid;
      a.exit_out = out_ch.exit_out;
      a.status = out_ch.status;
      sb.check_result(a);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    int sent;
    int burst;
    int k;
    sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = '0;
    in_ch.pid = '0;
    in_ch.owner_handle = '0;
    in_ch.start_slot = '0;
    in_ch.exit_code = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(MODE_LOOKUP, 7'd1, '0, '0, '0);
    issue(MODE_GET_EXIT, PID_W'(NSLOTS), '0, '0, '0);
    issue(MODE_LOOKUP, '0, '1, '1, '1);
    issue(MODE_GET_EXIT, PID_W'(NSLOTS + 1), '0, '0, '0);
    issue(MODE_SET_EXIT, PID_LAST, '1, '1, 32'h1234_5678);
    issue(MODE_CLEAR, '0, '0, '0, '0);
    issue(MODE_CLEAR, PID_LAST, '1, '1, '1);
    for (k = MODE_CLEAR + 1; k <= MODE_LAST; k++) begin
      issue(MODE_W'(k), '1, '1, '1, '1);
    end
    issue(MODE_ALLOC, '0, '1, '0, '1);
    issue(MODE_ALLOC, '1, '0, '1, '0);
    issue(MODE_ALLOC, '0, 16'h1234, '1, '0);
    issue(MODE_LOOKUP, 7'd1, '0, '0, '0);
    issue(MODE_SET_EXIT, PID_W'(NSLOTS), '0, '0, 32'h7FFF_FFFF);
    issue(MODE_SET_EXIT, 7'd1, '0, '0, 32'h8000_0000);
    issue(MODE_GET_EXIT, PID_W'(NSLOTS), '0, '0, '0);
    issue(MODE_GET_EXIT, 7'd1, '0, '0, '0);
    issue(MODE_CLEAR, 7'd1, '0, '0, '0);
    issue(MODE_GET_EXIT, 7'd1, '0, '0, '0);
    issue(MODE_LOOKUP, 7'd1, '0, '0, '0);
    issue(MODE_ALLOC, '0, 16'hA5A5, '0, '0);
    issue(MODE_GET_EXIT, 7'd1, '0, '0, '0);
    issue(MODE_LOOKUP, PID_W'(NSLOTS), '0, '0, '0);

    // Fill the table, then free the last slot: a probe from slot zero gives
    // up one slot short of it, while a probe started on it takes it.
    for (k = 0; k < NSLOTS + 4; k++) begin
      issue(MODE_ALLOC, '0, OWNER_W'($urandom), START_W'($urandom), $urandom);
      idle_sender($urandom_range(0, 2));
    end
    issue(MODE_CLEAR, PID_W'(NSLOTS), '0, '0, '0);
    issue(MODE_ALLOC, '0, OWNER_W'($urandom), '0, '0);
    issue(MODE_ALLOC, '0, OWNER_W'($urandom), '1, '0);
    issue(MODE_LOOKUP, PID_W'(NSLOTS), '0, '0, '0);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 3 || ph == 8) hold_req = 1'b1;
      if (ph == 5 || ph == 10) wait_drained();
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 40);
        for (k = 0; k < burst; k++) begin
          case (ph % 3)
            0: send_request(random_request(12, 50));
            1: send_request(random_request(30, 20));
            default: send_request(random_request(55, 10));
          endcase
        end
        sent += burst;
        idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
